// ===== hdl/servo_bus_frame_engine_macros.svh =====
// Assertion macros shared by the frame engine's checker.
`ifndef SERVO_BUS_FRAME_ENGINE_MACROS_SVH
`define SERVO_BUS_FRAME_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while reset is asserted.
`define SBFE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame engine check failed");

// Next-cycle implication, sampled on clk and quiet while reset is asserted.
`define SBFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame engine check failed");

`endif

// ===== hdl/sbfe_pkg.sv =====
// Types and constants shared by the servo bus frame engine modules.
package sbfe_pkg;

	// Input item actions.
	localparam logic [1:0] ACT_MOVE = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_RX   = 2'd2;

	// Result item kinds.
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// Frame constants.
	localparam logic [7:0] FRAME_HEADER  = 8'h55;
	localparam logic [7:0] CMD_MOVE      = 8'd1;
	localparam logic [7:0] CMD_READ_POS  = 8'd28;
	localparam logic [7:0] LEN_MOVE      = 8'd7;
	localparam logic [7:0] LEN_READ      = 8'd3;
	localparam logic [7:0] MIN_REPLY_LEN = 8'd3;
	localparam logic [15:0] LIMIT_RESET  = 16'd1000;

	// Byte positions.
	localparam logic [3:0] IDX_MOVE_LAST = 4'd9;
	localparam logic [3:0] IDX_READ_LAST = 4'd5;
	localparam logic [3:0] RX_IDX_HDR0   = 4'd0;
	localparam logic [3:0] RX_IDX_HDR1   = 4'd1;
	localparam logic [3:0] RX_IDX_ID     = 4'd2;
	localparam logic [3:0] RX_IDX_LEN    = 4'd3;
	localparam logic [3:0] RX_IDX_CMD    = 4'd4;
	localparam logic [3:0] RX_IDX_POS_LO = 4'd5;
	localparam logic [3:0] RX_IDX_POS_HI = 4'd6;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  dev_id;
		logic [15:0] target_position;
		logic [15:0] move_time;
		logic [7:0]  rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic        status;
		logic [15:0] read_position;
	} out_item_t;

	// Work handed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_MOVE,
		OP_READ,
		OP_REJECT,
		OP_REPORT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  dev_id;
		logic [15:0] target;
		logic [15:0] move_time;
		logic        status;
		logic [15:0] position;
	} cmd_t;

endpackage

// ===== hdl/sbfe_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
module sbfe_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sbfe_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output sbfe_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbfe_pkg::cmd_t   slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/sbfe_front.sv =====
// Front end: accepts items, checks moves, tracks reply reception, issues commands.
module sbfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  sbfe_pkg::in_item_t  request,
	input  logic                cfg_wr,
	input  logic [15:0]         cfg_data,
	output logic                cmd_push,
	output sbfe_pkg::cmd_t      cmd
);

	logic [15:0] limit_q;
	logic        awaiting_q;
	logic [7:0]  awaited_id_q;
	logic [3:0]  rx_idx_q;
	logic [7:0]  rx_sum_q;
	logic        rx_bad_q;
	logic [7:0]  pos_low_q;
	logic [7:0]  pos_high_q;

	logic        rx_take;
	logic        rx_final;
	logic        reply_bad;

	assign rx_take   = accept && (request.action == sbfe_pkg::ACT_RX) && awaiting_q;
	assign rx_final  = (rx_idx_q > sbfe_pkg::RX_IDX_POS_HI);
	assign reply_bad = rx_bad_q || ((~rx_sum_q) != request.rx_byte);

	// Command built from the accepted item.
	always_comb begin
		cmd           = '0;
		cmd.dev_id    = request.dev_id;
		cmd.target    = request.target_position;
		cmd.move_time = request.move_time;
		cmd_push      = 1'b0;
		case (request.action)
			sbfe_pkg::ACT_MOVE: begin
				cmd_push = accept;
				cmd.op   = (request.target_position > limit_q) ?
					sbfe_pkg::OP_REJECT : sbfe_pkg::OP_MOVE;
			end
			sbfe_pkg::ACT_READ: begin
				cmd_push = accept;
				cmd.op   = sbfe_pkg::OP_READ;
			end
			sbfe_pkg::ACT_RX: begin
				cmd_push     = rx_take && rx_final;
				cmd.op       = sbfe_pkg::OP_REPORT;
				cmd.status   = reply_bad;
				cmd.position = reply_bad ? 16'd0 : {pos_high_q, pos_low_q};
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	// Position limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sbfe_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= cfg_data;
		end
	end

	// Reply reception state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b0;
			awaited_id_q <= '0;
			rx_idx_q     <= '0;
			rx_sum_q     <= '0;
			rx_bad_q     <= 1'b0;
			pos_low_q    <= '0;
			pos_high_q   <= '0;
		end else if (accept && (request.action == sbfe_pkg::ACT_READ)) begin
			awaiting_q   <= 1'b1;
			awaited_id_q <= request.dev_id;
			rx_idx_q     <= '0;
			rx_sum_q     <= '0;
			rx_bad_q     <= 1'b0;
			pos_low_q    <= '0;
			pos_high_q   <= '0;
		end else if (rx_take) begin
			rx_idx_q <= rx_idx_q + 1'b1;
			case (rx_idx_q)
				sbfe_pkg::RX_IDX_HDR0, sbfe_pkg::RX_IDX_HDR1: begin
					if (request.rx_byte != sbfe_pkg::FRAME_HEADER) begin
						rx_bad_q <= 1'b1;
					end
				end
				sbfe_pkg::RX_IDX_ID: begin
					if (request.rx_byte != awaited_id_q) begin
						rx_bad_q <= 1'b1;
					end
					rx_sum_q <= rx_sum_q + request.rx_byte;
				end
				sbfe_pkg::RX_IDX_LEN: begin
					if (request.rx_byte < sbfe_pkg::MIN_REPLY_LEN) begin
						rx_bad_q <= 1'b1;
					end
					rx_sum_q <= rx_sum_q + request.rx_byte;
				end
				sbfe_pkg::RX_IDX_CMD: begin
					rx_sum_q <= rx_sum_q + request.rx_byte;
				end
				sbfe_pkg::RX_IDX_POS_LO: begin
					rx_sum_q  <= rx_sum_q + request.rx_byte;
					pos_low_q <= request.rx_byte;
				end
				sbfe_pkg::RX_IDX_POS_HI: begin
					rx_sum_q   <= rx_sum_q + request.rx_byte;
					pos_high_q <= request.rx_byte;
				end
				default: begin
					// Checksum byte: the report goes out and reception ends.
					awaiting_q <= 1'b0;
					rx_idx_q   <= '0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/sbfe_back.sv =====
// Back end: expands queued commands into result items, one per cycle while results are taken.
module sbfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_empty,
	input  sbfe_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	output logic                 empty,
	input  logic                 pop,
	output sbfe_pkg::out_item_t  result
);

	logic                busy_q;
	sbfe_pkg::cmd_t      cur_q;
	logic [3:0]          idx_q;
	logic [7:0]          csum_q;
	logic                out_valid_q;
	sbfe_pkg::out_item_t out_q;

	logic                advance;
	logic [7:0]          csum_next;
	logic [3:0]          last_idx;
	logic [7:0]          frame_byte;
	sbfe_pkg::out_item_t item;

	assign advance = !out_valid_q || pop;
	assign cmd_pop = !busy_q && !cmd_empty;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// Inverted-sum checksum of the frame, worked out when a command is loaded.
	always_comb begin
		if (cmd.op == sbfe_pkg::OP_MOVE) begin
			csum_next = ~(cmd.dev_id + sbfe_pkg::LEN_MOVE + sbfe_pkg::CMD_MOVE
				+ cmd.target[7:0] + cmd.target[15:8]
				+ cmd.move_time[7:0] + cmd.move_time[15:8]);
		end else begin
			csum_next = ~(cmd.dev_id + sbfe_pkg::LEN_READ + sbfe_pkg::CMD_READ_POS);
		end
	end

	// Frame byte at the current position.
	always_comb begin
		frame_byte = 8'd0;
		if (cur_q.op == sbfe_pkg::OP_MOVE) begin
			last_idx = sbfe_pkg::IDX_MOVE_LAST;
			case (idx_q)
				4'd0, 4'd1: frame_byte = sbfe_pkg::FRAME_HEADER;
				4'd2:       frame_byte = cur_q.dev_id;
				4'd3:       frame_byte = sbfe_pkg::LEN_MOVE;
				4'd4:       frame_byte = sbfe_pkg::CMD_MOVE;
				4'd5:       frame_byte = cur_q.target[7:0];
				4'd6:       frame_byte = cur_q.target[15:8];
				4'd7:       frame_byte = cur_q.move_time[7:0];
				4'd8:       frame_byte = cur_q.move_time[15:8];
				default:    frame_byte = csum_q;
			endcase
		end else if (cur_q.op == sbfe_pkg::OP_READ) begin
			last_idx = sbfe_pkg::IDX_READ_LAST;
			case (idx_q)
				4'd0, 4'd1: frame_byte = sbfe_pkg::FRAME_HEADER;
				4'd2:       frame_byte = cur_q.dev_id;
				4'd3:       frame_byte = sbfe_pkg::LEN_READ;
				4'd4:       frame_byte = sbfe_pkg::CMD_READ_POS;
				default:    frame_byte = csum_q;
			endcase
		end else begin
			last_idx = 4'd0;
		end
	end

	// Result item for the current position.
	always_comb begin
		item      = '0;
		item.last = (idx_q == last_idx);
		case (cur_q.op)
			sbfe_pkg::OP_REJECT: begin
				item.kind = sbfe_pkg::KIND_REJECT;
			end
			sbfe_pkg::OP_REPORT: begin
				item.kind          = sbfe_pkg::KIND_DONE;
				item.status        = cur_q.status;
				item.read_position = cur_q.position;
			end
			default: begin
				item.kind    = sbfe_pkg::KIND_TX;
				item.tx_byte = frame_byte;
			end
		endcase
	end

	// Command register and byte counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && advance) begin
			if (item.last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q  <= cmd;
			csum_q <= csum_next;
		end
	end

	// Output register holding the oldest waiting result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_q && advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && advance) begin
			out_q <= item;
		end
	end

endmodule

// ===== hdl/servo_bus_frame_engine.sv =====
// Bus-servo frame engine: move and read frames out, position replies in.
//
// Items enter through push/full and results leave through empty/pop. The front end takes
// one item per cycle while its command queue has room; received reply bytes and idle
// bytes are absorbed there and cause no result until the eighth reply byte. The back end
// loads one command and then sends one result per cycle while results are being taken:
// ten frame bytes for a move, six for a read request, and a single result for a
// rejection or a reply report. That serializer sets the sustained rate; CMD_DEPTH commands
// can wait in between. The position limit is written through cfg_valid/cfg_ready, which
// is always ready, and resets to 1000.
module servo_bus_frame_engine #(
	parameter int CMD_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sbfe_pkg::in_item_t  request,
	output logic                empty,
	input  logic                pop,
	output sbfe_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic           accept;
	logic           cmd_push;
	sbfe_pkg::cmd_t cmd_in;
	logic           cmd_pop;
	logic           cmd_empty;
	sbfe_pkg::cmd_t cmd_out;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	sbfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.request  (request),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	sbfe_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	sbfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== hdl/sbfe_checker.sv =====
// Port-level checker for the frame engine, bound to the top level.
`include "servo_bus_frame_engine_macros.svh"

module sbfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input sbfe_pkg::out_item_t result
);

	logic show_tx;
	logic show_reject;
	logic show_bad;

	assign show_tx     = !empty && (result.kind == sbfe_pkg::KIND_TX);
	assign show_reject = !empty && (result.kind == sbfe_pkg::KIND_REJECT);
	assign show_bad    = !empty && (result.kind == sbfe_pkg::KIND_DONE) && result.status;

	// A waiting result stays put until it is taken.
	`SBFE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

	// Frame bytes carry no status and no position.
	`SBFE_ASSERT_NOW(a_tx_clean, show_tx, !result.status && result.read_position == 16'd0)

	// A rejection is a single, final result.
	`SBFE_ASSERT_NOW(a_reject_last, show_reject, result.last && result.tx_byte == 8'd0)

	// A bad reply reports no position.
	`SBFE_ASSERT_NOW(a_bad_no_pos, show_bad, result.read_position == 16'd0 && result.last)

endmodule

bind servo_bus_frame_engine sbfe_checker u_sbfe_checker (.*);
